>>> hdl/smed_pkg.sv
// Package for the sort-based median block: payload structs, cell control struct
// and field widths. Depends on nothing; every other file imports it.
package smed_pkg;

  localparam int unsigned VALUE_W  = 24;
  localparam int unsigned MEDIAN_W = 25;
  localparam int unsigned COUNT_W  = 7;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } smed_in_t;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_x2;
    logic [COUNT_W-1:0]         count;
    logic                       overflow;
  } smed_out_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the broadcast sample in sorted position
    logic drain;   // shift every entry one cell towards the head
  } cell_ctrl_t;

endpackage

>>> hdl/smed_cell.sv
// One cell of the sorted insertion chain: holds one sample and exchanges data
// with its two neighbours. Depends on smed_pkg.
module smed_cell import smed_pkg::*; (
  input  logic                      clk_i,
  input  cell_ctrl_t                ctrl_i,
  input  logic                      occ_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      prev_gt_i,
  input  logic signed [VALUE_W-1:0] prev_val_i,
  input  logic signed [VALUE_W-1:0] next_val_i,
  output logic signed [VALUE_W-1:0] val_o,
  output logic                      gt_o
);

  logic signed [VALUE_W-1:0] val_q, val_d;

  // Strictly greater, so an equal new sample lands behind the existing ones.
  assign gt_o  = occ_i && (val_q > value_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.drain) begin
      val_d = next_val_i;
    end else if (ctrl_i.insert) begin
      if (prev_gt_i) begin
        val_d = prev_val_i;
      end else if (!occ_i || gt_o) begin
        val_d = value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

>>> hdl/sort_based_median.sv
// Sort-based median. Samples (signed Q15.8) enter one transaction per cycle and
// are dropped into a chain of MAX_ITEMS cells that keeps them in ascending
// order, so a set loads at full rate: the input is never stalled while a set is
// being loaded. On the sample marked last the chain is shifted towards its head
// until the lower middle entry sits in the first cell; then, once the output
// register is free or being emptied, twice the median (Q16.8, exact) is formed
// in it. The input is stalled from the closing sample until the result is
// formed. Samples beyond MAX_ITEMS are discarded and reported through the
// overflow flag. The result register decouples the two sides: the next set may
// start loading while a result still waits to be taken. The count field is
// seven bits wide and wraps when MAX_ITEMS exceeds 127. Depends on smed_pkg and
// smed_cell.
module sort_based_median import smed_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  smed_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output smed_out_t out_data_o
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_DRAIN = 2'd1;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          dropped_q, dropped_d;
  logic [CW-1:0] n_q, n_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] shift_q, shift_d;
  logic          out_valid_q, out_valid_d;
  smed_out_t     out_q;

  logic          in_acc;
  logic          room;
  logic          load_out;
  logic [CW-1:0] n_new;
  cell_ctrl_t    ctrl;

  logic signed [VALUE_W-1:0] cell_val [MAX_ITEMS];
  logic                      cell_gt  [MAX_ITEMS];

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign room       = (fill_q < CW'(MAX_ITEMS));
  assign n_new      = room ? fill_q + CW'(1) : fill_q;

  // The result is formed once the lower middle entry has reached the head cell
  // and the output register is free or being emptied in this cycle.
  assign load_out = (state_q == S_DRAIN) && (shift_q == '0) &&
                    (!out_valid_q || !out_stall_i);

  assign ctrl.insert = in_acc && room;
  assign ctrl.drain  = (state_q == S_DRAIN) && (shift_q != '0);

  // The cell chain. Occupancy follows from the fill count, so the cells carry
  // no flag of their own.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                      prev_gt;
    logic signed [VALUE_W-1:0] prev_val;
    logic signed [VALUE_W-1:0] next_val;

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_val = in_data_i.value;
    end else begin : g_body
      assign prev_gt  = cell_gt[i-1];
      assign prev_val = cell_val[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    smed_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (CW'(i) < fill_q),
      .value_i    (in_data_i.value),
      .prev_gt_i  (prev_gt),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    dropped_d   = dropped_q;
    n_d         = n_q;
    ovf_d       = ovf_q;
    shift_d     = shift_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          fill_d    = n_new;
          dropped_d = dropped_q || !room;
          if (in_data_i.last) begin
            n_d     = n_new;
            ovf_d   = dropped_q || !room;
            // Shifts needed to bring entry floor((n-1)/2) to the head cell.
            shift_d = (n_new - CW'(1)) >> 1;
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (shift_q != '0) begin
          shift_d = shift_q - CW'(1);
        end else if (load_out) begin
          out_valid_d = 1'b1;
          fill_d      = '0;
          dropped_d   = 1'b0;
          state_d     = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      fill_q      <= '0;
      dropped_q   <= 1'b0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      dropped_q   <= dropped_d;
      shift_q     <= shift_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    ovf_q <= ovf_d;
    if (load_out) begin
      // Odd count: the middle entry twice. Even count: the two middle entries.
      out_q.median_x2 <= MEDIAN_W'(cell_val[0]) +
                         (n_q[0] ? MEDIAN_W'(cell_val[0]) : MEDIAN_W'(cell_val[1]));
      out_q.count     <= COUNT_W'(n_q);
      out_q.overflow  <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/smed_checker.sv
// Port-level checker for sort_based_median, attached by the bind at the end.
// Depends on smed_pkg.
module smed_checker import smed_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input smed_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input smed_out_t out_data_o
);

  // A stalled result transaction holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or vanished");

  // Dropping only happens once the store is full.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.count == COUNT_W'(MAX_ITEMS))
    else $error("overflow reported with store not full");

  // An odd count gives twice one entry, which is always even.
  a_odd_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.count[0] |-> !out_data_o.median_x2[0])
    else $error("odd count gave an odd doubled median");

  // Every set holds at least one sample.
  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (MAX_ITEMS > 127) || (out_data_o.count != '0))
    else $error("result with zero count");

  // Once the closing sample of a set is taken, the input holds off while the
  // chain drains.
  a_close_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last |=> in_stall_o)
    else $error("input not stalled after the closing sample");

endmodule

bind sort_based_median smed_checker #(.MAX_ITEMS(MAX_ITEMS)) u_smed_checker (.*);

>>> tb/sort_based_median_checker.sv
// Scoreboard for the sort-based median block: mirrors the sorted store, forms
// twice the median on every closing sample and compares each result in order.
// Depends on smed_pkg for the payload structs and field widths.
`timescale 1ns / 1ps

module sort_based_median_checker import smed_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  smed_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  smed_out_t out_data_i,
  output int        mismatches_o,
  output int        pending_o
);

  logic signed [VALUE_W-1:0] kept [MAX_ITEMS];
  int unsigned               kept_n;
  logic                      dropped;
  smed_out_t                 median_due [$];
  int                        mismatches;
  int                        due_n;

  assign mismatches_o = mismatches;
  assign pending_o    = due_n;

  always @(posedge clk_i or negedge rst_ni) begin : track
    int unsigned               pos;
    logic signed [MEDIAN_W-1:0] lower;
    logic signed [MEDIAN_W-1:0] upper;
    smed_out_t                 want;
    if (!rst_ni) begin
      kept_n     = 0;
      dropped    = 1'b0;
      mismatches = 0;
      median_due.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (kept_n < MAX_ITEMS) begin
          pos = kept_n;
          while (pos > 0 && kept[pos-1] > in_data_i.value) begin
            kept[pos] = kept[pos-1];
            pos--;
          end
          kept[pos] = in_data_i.value;
          kept_n++;
        end else begin
          dropped = 1'b1;
        end
        if (in_data_i.last) begin
          // Both indices coincide for an odd count, so one sum covers both cases.
          lower          = kept[(kept_n - 1) / 2];
          upper          = kept[kept_n / 2];
          want.median_x2 = lower + upper;
          want.count     = COUNT_W'(kept_n);
          want.overflow  = dropped;
          median_due.push_back(want);
          kept_n  = 0;
          dropped = 1'b0;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (median_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected median result: x2=%0d count=%0d overflow=%0b",
                     out_data_i.median_x2, out_data_i.count, out_data_i.overflow);
          end
        end else begin
          want = median_due.pop_front();
          if (out_data_i.median_x2 !== want.median_x2 || out_data_i.count !== want.count ||
              out_data_i.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("median mismatch: got x2=%0d count=%0d overflow=%0b,",
                       out_data_i.median_x2, out_data_i.count, out_data_i.overflow,
                       " expected x2=%0d count=%0d overflow=%0b",
                       want.median_x2, want.count, want.overflow);
            end
          end
        end
      end
    end
    due_n = median_due.size();
  end

endmodule

>>> tb/sort_based_median_test.sv
// Top of the sort-based median testbench: clock, reset, sample sets and output
// back-pressure, with the verdict at the end. Depends on smed_pkg, the block
// itself and sort_based_median_checker, which does all the predicting.
`timescale 1ns / 1ps

module sort_based_median_test import smed_pkg::*;;

  localparam int unsigned SET_CAP       = 64;
  localparam int unsigned SAMPLE_TARGET = 1950;
  localparam int unsigned IDLE_PERCENT  = 23;
  // A set drains well within this, so the wait is ample.
  localparam int unsigned DRAIN_CYCLES  = 2 * SET_CAP;
  // Far beyond the slowest legal run, even with every gap and stall at its longest.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  // The calm window: samples in this range go through with no idling on either side.
  localparam int unsigned CALM_FROM     = 700;
  localparam int unsigned CALM_TO       = 1100;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  smed_in_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      calm      = 1'b0;
  logic      in_stall;
  logic      out_valid;
  smed_out_t out_data;

  int          mismatches;
  int          pending;
  int unsigned cycles        = 0;
  int unsigned samples_sent  = 0;
  int unsigned sets_sent     = 0;
  int unsigned crowded_sets  = 0;

  // 8 ns period: four high, four low.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sort_based_median #(
    .MAX_ITEMS(SET_CAP)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  sort_based_median_checker #(
    .MAX_ITEMS(SET_CAP)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  // The receiving side holds off a result in roughly a quarter of the cycles,
  // independently of whether anything is on offer, so stalls land on every
  // phase of the drain as well as on results that are already waiting.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results still due", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Offers one sample and returns once the transaction has been taken. Idle
  // cycles before the offer are random; once valid is up it stays up, with the
  // payload unchanged, until the block stops stalling.
  task automatic send_sample(input logic signed [VALUE_W-1:0] v, input logic closing);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{value: v, last: closing};
    do @(posedge clk); while (in_stall);
    samples_sent++;
    if (closing) sets_sent++;
  endtask

  initial begin : stimulus
    int unsigned               set_len;
    int unsigned               dice;
    int unsigned               rand_sets;
    logic signed [VALUE_W-1:0] v;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets. Single samples at both ends of the range give the largest
    // and smallest possible doubled medians; the pairs check the even-count sum
    // at its extremes and across zero.
    send_sample(VALUE_MAX, 1'b1);
    send_sample(VALUE_MIN, 1'b1);
    send_sample(VALUE_MIN, 1'b0);
    send_sample(VALUE_MAX, 1'b1);
    send_sample(VALUE_MAX, 1'b0);
    send_sample(VALUE_MAX, 1'b1);
    send_sample(VALUE_MIN, 1'b0);
    send_sample(VALUE_MIN, 1'b1);
    send_sample(VALUE_W'(0), 1'b1);
    // Equal samples must sit side by side without disturbing the result.
    send_sample(VALUE_W'(-1), 1'b0);
    send_sample(VALUE_W'(-1), 1'b0);
    send_sample(VALUE_W'(-1), 1'b1);
    // Strictly descending input, so every insertion goes to the head of the chain.
    send_sample(VALUE_W'(1280), 1'b0);
    send_sample(VALUE_W'(768), 1'b0);
    send_sample(VALUE_W'(256), 1'b0);
    send_sample(VALUE_W'(-512), 1'b1);
    // Mixed order with a run of duplicates around the middle.
    send_sample(VALUE_W'(7), 1'b0);
    send_sample(VALUE_W'(7), 1'b0);
    send_sample(VALUE_W'(-7), 1'b0);
    send_sample(VALUE_W'(0), 1'b0);
    send_sample(VALUE_W'(7), 1'b1);

    // Random sets. The first three exercise a store filled exactly, a closing
    // sample that is itself dropped, and a set that overruns by several samples.
    // After that most sets are short, with the odd long or over-full one.
    rand_sets = 0;
    while (samples_sent < SAMPLE_TARGET) begin
      calm <= (samples_sent >= CALM_FROM && samples_sent < CALM_TO);
      if (rand_sets == 0) begin
        set_len = SET_CAP;
      end else if (rand_sets == 1) begin
        set_len = SET_CAP + 1;
      end else if (rand_sets == 2) begin
        set_len = SET_CAP + 6;
      end else begin
        dice = $urandom_range(0, 99);
        if (dice < 70) set_len = $urandom_range(1, 12);
        else if (dice < 85) set_len = $urandom_range(13, SET_CAP - 1);
        else if (dice < 93) set_len = SET_CAP;
        else set_len = $urandom_range(SET_CAP + 1, SET_CAP + 8);
      end
      if (set_len > SET_CAP) crowded_sets++;

      for (int unsigned k = 0; k < set_len; k++) begin
        // Mostly full-range values, with a share of extremes and a small pool
        // of values near zero so that duplicates turn up often.
        dice = $urandom_range(0, 9);
        if (dice == 0) v = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
        else if (dice < 3) v = VALUE_W'(int'($urandom_range(0, 6)) - 3);
        else v = VALUE_W'($urandom);
        send_sample(v, k == set_len - 1);
      end
      rand_sets++;
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // Wait for the final closing sample to reach the scoreboard, then wait
    // for every result and give the block time to show anything spurious.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples in %0d sets, %0d of them beyond the store's capacity",
             samples_sent, sets_sent, crowded_sets);
    $display("mismatching or unexpected results: %0d", mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/smed_pkg.sv
hdl/smed_cell.sv
hdl/sort_based_median.sv
hdl/smed_checker.sv
tb/sort_based_median_checker.sv
tb/sort_based_median_test.sv
